@@ rtl/bfbt_pkg.sv @@
package bfbt_pkg;

  localparam int FRAME_DEPTH = 32;
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int WD_W        = 16;

  typedef logic [1:0] req_t;
  typedef logic [2:0] kind_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] phase_t;

  localparam logic [WD_W-1:0] ECHO_TIMEOUT_RST = 16'd200;

  localparam logic [PADDR_W-3:0] REG_ECHO_TIMEOUT = '0;

  localparam req_t REQ_RX    = 2'd0;
  localparam req_t REQ_BREAK = 2'd1;
  localparam req_t REQ_TICK  = 2'd2;
  localparam req_t REQ_TX    = 2'd3;

  localparam kind_t KIND_FRAME   = 3'd0;
  localparam kind_t KIND_SEND    = 3'd1;
  localparam kind_t KIND_BRK_ON  = 3'd2;
  localparam kind_t KIND_BRK_OFF = 3'd3;
  localparam kind_t KIND_STATUS  = 3'd4;

  localparam status_t ST_ECHOED    = 3'd0;
  localparam status_t ST_DONE      = 3'd1;
  localparam status_t ST_TIMEOUT   = 3'd2;
  localparam status_t ST_COLLISION = 3'd3;
  localparam status_t ST_BUSY      = 3'd4;

  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_ECHO = 2'd1;
  localparam phase_t PH_OPEN = 2'd2;
  localparam phase_t PH_BRK  = 2'd3;

  localparam logic [CNT_W-1:0] FRAME_LEN_PAIR  = CNT_W'(2);
  localparam logic [CNT_W-1:0] FRAME_LEN_SHORT = CNT_W'(4);

  typedef struct packed {
    logic    latch;
    logic    store;
    logic    emit;
    kind_t   emit_kind;
    status_t emit_status;
    logic    set_phase;
    phase_t  phase_val;
    logic    set_swl;
    logic    clr_swl;
    logic    set_to;
    logic    clr_to;
    logic    load_wd;
    logic    dec_wd;
    logic    clr_count;
    logic    end_frame;
    logic    idx_clr;
    logic    idx_inc;
  } cmd_t;

  typedef struct packed {
    req_t   req;
    phase_t phase;
    logic   swl;
    logic   timed_out;
    logic   wd_expire;
    logic   frame_ok;
    logic   rd_last;
    logic   out_free;
  } stat_t;

endpackage

@@ rtl/bfbt_if.sv @@
interface bfbt_req_if;
  import bfbt_pkg::*;

  logic valid;
  logic ready;
  req_t req_type;
  logic [7:0] data;
  logic tx_last;

  modport source (output valid, output req_type, output data, output tx_last, input ready);
  modport sink (input valid, input req_type, input data, input tx_last, output ready);
endinterface

interface bfbt_res_if;
  import bfbt_pkg::*;

  logic valid;
  logic ready;
  kind_t kind;
  logic [7:0] data_res;
  logic last;
  status_t status;

  modport source (output valid, output kind, output data_res, output last, output status,
                  input ready);
  modport sink (input valid, input kind, input data_res, input last, input status,
                output ready);
endinterface

@@ rtl/break_framed_bus_transceiver.sv @@
// Half-duplex frame engine for a bus whose frames end in a line break.
// req_ch takes one event per item: received byte, break seen, watchdog tick,
// or byte to transmit (tx_last marks the telegram's final byte).
// res_ch returns frame bytes (last on the final one), bytes to put on the
// line, break on/off requests and transmit status codes.
// echo_timeout_ticks sits at byte address 0 of the APB port.
// Flow: an item is latched when req_ch takes it, then worked in S_EXEC.
// A break that closes a frame passes S_FRAME and, for each delivered byte,
// S_RD and S_FB; when it also ends a telegram, S_FINST sends the status
// first. Bytes stream from the frame buffer RAM (address, then registered
// read). The buffer holds 32 bytes counting the break, so at most 31 are
// delivered; longer frames are dropped.
// A single output register holds one result: req_ch is ready again while
// it waits, and the engine stalls only when it has a further result and
// res_ch still has not taken the previous one.
// Reset: empty buffer, transmitter idle, first frame after reset dropped,
// echo timeout 200 ticks; req_ch is not ready while rst is high.
module break_framed_bus_transceiver (
  input  logic                         clk,
  input  logic                         rst,
  bfbt_req_if.sink                     req_ch,
  bfbt_res_if.source                   res_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfbt_pkg::PADDR_W-1:0] paddr,
  input  logic [bfbt_pkg::PDATA_W-1:0] pwdata,
  output logic [bfbt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bfbt_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;

  assign pready       = 1'b1;
  assign req_ch.ready = in_ready;

  bfbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bfbt_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_req_type  (req_ch.req_type),
    .in_data      (req_ch.data),
    .in_tx_last   (req_ch.tx_last),
    .out_valid    (res_ch.valid),
    .out_ready    (res_ch.ready),
    .out_kind     (res_ch.kind),
    .out_data_res (res_ch.data_res),
    .out_last     (res_ch.last),
    .out_status   (res_ch.status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

endmodule

@@ rtl/bfbt_ram.sv @@
module bfbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bfbt_ctrl.sv @@
module bfbt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bfbt_pkg::stat_t st,
  output bfbt_pkg::cmd_t  cmd
);
  import bfbt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_BRKON = 3'd2;
  localparam logic [2:0] S_FINST = 3'd3;
  localparam logic [2:0] S_FRAME = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_FB    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_txn;

  assign in_ready = (state == S_IDLE) && !rst;
  assign in_txn   = (st.phase == PH_ECHO) || (st.phase == PH_OPEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.req)
          REQ_RX: begin
            if (st.phase != PH_ECHO) begin
              cmd.store  = 1'b1;
              state_next = S_IDLE;
            end else if (st.out_free) begin
              cmd.store       = 1'b1;
              cmd.emit        = 1'b1;
              cmd.emit_kind   = KIND_STATUS;
              cmd.emit_status = ST_ECHOED;
              if (st.swl) begin
                state_next = S_BRKON;
              end else begin
                cmd.set_phase = 1'b1;
                cmd.phase_val = PH_OPEN;
                state_next    = S_IDLE;
              end
            end
          end
          REQ_BREAK: begin
            if (in_txn) begin
              if (st.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_kind   = KIND_STATUS;
                cmd.emit_status = ST_COLLISION;
                cmd.set_phase   = 1'b1;
                cmd.phase_val   = PH_IDLE;
                cmd.clr_swl     = 1'b1;
                cmd.clr_to      = 1'b1;
                state_next      = S_IDLE;
              end
            end else if (st.phase == PH_BRK) begin
              if (st.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = KIND_BRK_OFF;
                state_next    = S_FINST;
              end
            end else begin
              state_next = S_FRAME;
            end
          end
          REQ_TICK: begin
            if ((st.phase == PH_ECHO || st.phase == PH_BRK) && st.wd_expire) begin
              if (st.out_free) begin
                cmd.emit = 1'b1;
                if (st.phase == PH_ECHO) begin
                  cmd.set_to    = 1'b1;
                  cmd.emit_kind = KIND_BRK_ON;
                  cmd.set_phase = 1'b1;
                  cmd.phase_val = PH_BRK;
                  cmd.load_wd   = 1'b1;
                  state_next    = S_IDLE;
                end else begin
                  cmd.dec_wd    = 1'b1;
                  cmd.emit_kind = KIND_BRK_OFF;
                  state_next    = S_FINST;
                end
              end
            end else begin
              cmd.dec_wd = (st.phase == PH_ECHO) || (st.phase == PH_BRK);
              state_next = S_IDLE;
            end
          end
          REQ_TX: begin
            if (st.out_free) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (st.phase == PH_ECHO || st.phase == PH_BRK) begin
                cmd.emit_kind   = KIND_STATUS;
                cmd.emit_status = ST_BUSY;
              end else begin
                cmd.clr_count = (st.phase == PH_IDLE);
                cmd.clr_to    = (st.phase == PH_IDLE);
                cmd.emit_kind = KIND_SEND;
                cmd.set_swl   = 1'b1;
                cmd.set_phase = 1'b1;
                cmd.phase_val = PH_ECHO;
                cmd.load_wd   = 1'b1;
              end
            end
          end
        endcase
      end
      S_BRKON: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_BRK_ON;
          cmd.set_phase = 1'b1;
          cmd.phase_val = PH_BRK;
          cmd.load_wd   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FINST: begin
        if (st.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_STATUS;
          cmd.emit_status = st.timed_out ? ST_TIMEOUT : ST_DONE;
          cmd.set_phase   = 1'b1;
          cmd.phase_val   = PH_IDLE;
          cmd.clr_to      = 1'b1;
          cmd.clr_swl     = 1'b1;
          state_next      = (st.req == REQ_BREAK) ? S_FRAME : S_IDLE;
        end
      end
      S_FRAME: begin
        if (st.frame_ok) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_RD;
        end else begin
          cmd.end_frame = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RD: begin
        state_next = S_FB;
      end
      S_FB: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FRAME;
          if (st.rd_last) begin
            cmd.end_frame = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/bfbt_dp.sv @@
module bfbt_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  bfbt_pkg::cmd_t               cmd,
  output bfbt_pkg::stat_t              st,
  input  bfbt_pkg::req_t               in_req_type,
  input  logic [7:0]                   in_data,
  input  logic                         in_tx_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bfbt_pkg::kind_t              out_kind,
  output logic [7:0]                   out_data_res,
  output logic                         out_last,
  output bfbt_pkg::status_t            out_status,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfbt_pkg::PADDR_W-1:0] paddr,
  input  logic [bfbt_pkg::PDATA_W-1:0] pwdata,
  output logic [bfbt_pkg::PDATA_W-1:0] prdata
);
  import bfbt_pkg::*;

  req_t             req;
  logic [7:0]       data;
  logic             tx_last;
  logic [WD_W-1:0]  echo_timeout_ticks;
  logic [CNT_W-1:0] frame_count;
  logic             drop_pending;
  phase_t           tx_phase;
  logic [WD_W-1:0]  watchdog;
  logic             sent_was_last;
  logic             tx_timed_out;
  logic [ADDR_W-1:0] idx;
  logic [7:0]       rdata;
  logic             full;
  logic [CNT_W-1:0] total;
  logic             cfg_wr;
  logic             cfg_hit;
  logic [WD_W-1:0]  wd_load;
  logic             rd_last;

  assign full    = (frame_count == CNT_W'(FRAME_DEPTH));
  assign total   = full ? frame_count : frame_count + CNT_W'(1);
  assign rd_last = (CNT_W'(idx) + FRAME_LEN_PAIR) == total;
  assign wd_load = (echo_timeout_ticks == '0) ? WD_W'(1) : echo_timeout_ticks;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_ECHO_TIMEOUT);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? PDATA_W'(echo_timeout_ticks) : '0;

  assign st.req       = req;
  assign st.phase     = tx_phase;
  assign st.swl       = sent_was_last;
  assign st.timed_out = tx_timed_out;
  assign st.wd_expire = (watchdog <= WD_W'(1));
  assign st.frame_ok  = !(drop_pending || full) &&
                        ((total == FRAME_LEN_PAIR) || (total > FRAME_LEN_SHORT));
  assign st.rd_last   = rd_last;
  assign st.out_free  = !out_valid || out_ready;

  bfbt_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.store && !full),
    .waddr (frame_count[ADDR_W-1:0]),
    .wdata (data),
    .raddr (idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req     <= in_req_type;
      data    <= in_data;
      tx_last <= in_tx_last;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + ADDR_W'(1);
    end
    if (cmd.emit) begin
      out_kind     <= cmd.emit_kind;
      out_status   <= cmd.emit_status;
      out_last     <= (cmd.emit_kind == KIND_FRAME) && rd_last;
      if (cmd.emit_kind == KIND_SEND) begin
        out_data_res <= data;
      end else if (cmd.emit_kind == KIND_FRAME) begin
        out_data_res <= rdata;
      end else begin
        out_data_res <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_timeout_ticks <= ECHO_TIMEOUT_RST;
      frame_count        <= '0;
      drop_pending       <= 1'b1;
      tx_phase           <= PH_IDLE;
      watchdog           <= '0;
      sent_was_last      <= 1'b0;
      tx_timed_out       <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_wr) begin
        echo_timeout_ticks <= pwdata[WD_W-1:0];
      end
      if (cmd.clr_count || cmd.end_frame) begin
        frame_count <= '0;
      end else if (cmd.store && !full) begin
        frame_count <= frame_count + CNT_W'(1);
      end
      if (cmd.end_frame) begin
        drop_pending <= 1'b0;
      end else if (cmd.store && full) begin
        drop_pending <= 1'b1;
      end
      if (cmd.set_phase) begin
        tx_phase <= cmd.phase_val;
      end
      if (cmd.load_wd) begin
        watchdog <= wd_load;
      end else if (cmd.dec_wd && watchdog != '0) begin
        watchdog <= watchdog - WD_W'(1);
      end
      if (cmd.set_swl) begin
        sent_was_last <= tx_last;
      end else if (cmd.clr_swl) begin
        sent_was_last <= 1'b0;
      end
      if (cmd.set_to) begin
        tx_timed_out <= 1'b1;
      end else if (cmd.clr_to) begin
        tx_timed_out <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ verif/bfbt_checker.sv @@
`timescale 1ns / 1ps

module bfbt_checker (
  input  logic                         clk,
  input  logic                         rst,
  bfbt_req_if                          req_mon,
  bfbt_res_if                          res_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfbt_pkg::PADDR_W-1:0] paddr,
  input  logic [bfbt_pkg::PDATA_W-1:0] pwdata,
  input  logic                         pready,
  output int                           fail_count,
  output int                           pending
);
  import bfbt_pkg::*;

  localparam status_t ST_NONE = ST_ECHOED;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } bus_result_t;

  bus_result_t     due_results[$];
  bus_result_t     got;
  bus_result_t     want;

  logic [7:0]      frame_mem [FRAME_DEPTH];
  int unsigned     frame_len;
  logic            drop_frame;
  phase_t          tx_phase;
  logic [WD_W-1:0] wd_count;
  logic [WD_W-1:0] echo_timeout;
  logic            send_last;
  logic            timed_out;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(string what, bus_result_t g, bus_result_t w);
    if (fail_count < MAX_REPORTS)
      $display("bfbt check @%0t: %s: got k%0d d%02h l%0d s%0d, want k%0d d%02h l%0d s%0d",
               $time, what, g.kind, g.data, g.last, g.status,
               w.kind, w.data, w.last, w.status);
    fail_count++;
  endtask

  function automatic void push_result(kind_t k, logic [7:0] d, logic l, status_t s);
    bus_result_t r;
    r.kind   = k;
    r.data   = d;
    r.last   = l;
    r.status = s;
    due_results.push_back(r);
  endfunction

  function automatic void load_wd();
    wd_count = (echo_timeout == '0) ? WD_W'(1) : echo_timeout;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (frame_len < FRAME_DEPTH) begin
      frame_mem[frame_len] = b;
      frame_len++;
    end else begin
      drop_frame = 1'b1;
    end
  endfunction

  function automatic void close_telegram();
    push_result(KIND_BRK_OFF, 8'h00, 1'b0, ST_NONE);
    push_result(KIND_STATUS, 8'h00, 1'b0, timed_out ? ST_TIMEOUT : ST_DONE);
    tx_phase  = PH_IDLE;
    timed_out = 1'b0;
    send_last = 1'b0;
  endfunction

  function automatic void close_frame();
    int unsigned total;
    store_byte(8'h00);
    total = frame_len;
    if (!drop_frame && (total == FRAME_LEN_PAIR || total > FRAME_LEN_SHORT)) begin
      for (int unsigned i = 0; i + 1 < total; i++)
        push_result(KIND_FRAME, frame_mem[i], (i + 2 == total), ST_NONE);
    end
    drop_frame = 1'b0;
    frame_len  = 0;
  endfunction

  function automatic void step_transceiver(req_t r, logic [7:0] d, logic tl);
    case (r)
      REQ_RX: begin
        store_byte(d);
        if (tx_phase == PH_ECHO) begin
          push_result(KIND_STATUS, 8'h00, 1'b0, ST_ECHOED);
          if (send_last) begin
            push_result(KIND_BRK_ON, 8'h00, 1'b0, ST_NONE);
            tx_phase = PH_BRK;
            load_wd();
          end else begin
            tx_phase = PH_OPEN;
          end
        end
      end
      REQ_BREAK: begin
        if (tx_phase == PH_ECHO || tx_phase == PH_OPEN) begin
          push_result(KIND_STATUS, 8'h00, 1'b0, ST_COLLISION);
          tx_phase  = PH_IDLE;
          send_last = 1'b0;
          timed_out = 1'b0;
        end else begin
          if (tx_phase == PH_BRK)
            close_telegram();
          close_frame();
        end
      end
      REQ_TICK: begin
        if (tx_phase == PH_ECHO || tx_phase == PH_BRK) begin
          if (wd_count != '0)
            wd_count--;
          if (wd_count == '0) begin
            if (tx_phase == PH_ECHO) begin
              timed_out = 1'b1;
              push_result(KIND_BRK_ON, 8'h00, 1'b0, ST_NONE);
              tx_phase = PH_BRK;
              load_wd();
            end else begin
              close_telegram();
            end
          end
        end
      end
      default: begin
        if (tx_phase == PH_ECHO || tx_phase == PH_BRK) begin
          push_result(KIND_STATUS, 8'h00, 1'b0, ST_BUSY);
        end else begin
          if (tx_phase == PH_IDLE) begin
            frame_len = 0;
            timed_out = 1'b0;
          end
          push_result(KIND_SEND, d, 1'b0, ST_NONE);
          send_last = tl;
          tx_phase  = PH_ECHO;
          load_wd();
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      due_results.delete();
      frame_len    = 0;
      drop_frame   = 1'b1;
      tx_phase     = PH_IDLE;
      wd_count     = '0;
      echo_timeout = ECHO_TIMEOUT_RST;
      send_last    = 1'b0;
      timed_out    = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ECHO_TIMEOUT)
        echo_timeout = pwdata[WD_W-1:0];
      // results come from earlier items, so check before predicting this edge's item
      if (res_mon.valid && res_mon.ready) begin
        got.kind   = res_mon.kind;
        got.data   = res_mon.data_res;
        got.last   = res_mon.last;
        got.status = res_mon.status;
        if (due_results.size() == 0) begin
          report("result with none due", got, '0);
        end else begin
          want = due_results.pop_front();
          if (got.kind != want.kind)
            report("kind", got, want);
          if (got.data != want.data)
            report("data_res", got, want);
          if (got.last != want.last)
            report("last", got, want);
          if (got.status != want.status)
            report("status", got, want);
        end
      end
      if (req_mon.valid && req_mon.ready)
        step_transceiver(req_mon.req_type, req_mon.data, req_mon.tx_last);
    end
    pending <= due_results.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bfbt_pkg::*;

  localparam int LIMIT        = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int NPHASE       = 8;
  localparam int PHASE_ITEMS  = 54;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  int                 sent;
  bit                 quiet;
  bit                 hold_rx;
  logic [WD_W-1:0]    echo_to;

  bfbt_req_if req_ch ();
  bfbt_res_if res_ch ();

  break_framed_bus_transceiver uut (
    .clk     (clk),
    .rst     (rst),
    .req_ch  (req_ch),
    .res_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfbt_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic put_item(req_t r, logic [7:0] d, logic tl);
    int gap;
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r;
    req_ch.data     <= d;
    req_ch.tx_last  <= tl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_echo_timeout(logic [WD_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ECHO_TIMEOUT, 2'b00};
    pwdata  <= {(PDATA_W - WD_W)'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    echo_to = val;
  endtask

  task automatic rx_frame(int len);
    repeat (len) put_item(REQ_RX, 8'($urandom), rbit());
    put_item(REQ_BREAK, 8'($urandom), rbit());
  endtask

  task automatic telegram();
    int nb;
    int eff;
    int pick;
    bit in_brk;
    nb     = $urandom_range(1, 4);
    eff    = (echo_to == '0) ? 1 : int'(echo_to);
    in_brk = 1'b0;
    for (int i = 0; i < nb && !in_brk; i++) begin
      put_item(REQ_TX, 8'($urandom), (i == nb - 1));
      pick = $urandom_range(0, 9);
      if (pick == 7) begin
        // collision while waiting for the echo
        put_item(REQ_BREAK, 8'($urandom), rbit());
        return;
      end
      if (pick == 6 && eff <= 8) begin
        repeat (eff) put_item(REQ_TICK, 8'($urandom), rbit());
        in_brk = 1'b1;
      end else begin
        if (pick == 8 && eff > 1)
          repeat ($urandom_range(1, (eff > 8) ? 8 : eff - 1))
            put_item(REQ_TICK, 8'($urandom), rbit());
        if (pick == 9)
          put_item(REQ_TX, 8'($urandom), rbit());
        put_item(REQ_RX, 8'($urandom), rbit());
        if (i == nb - 1)
          in_brk = 1'b1;
        else if ($urandom_range(0, 3) == 0)
          put_item($urandom_range(0, 1) ? REQ_RX : REQ_TICK, 8'($urandom), rbit());
      end
    end
    pick = $urandom_range(0, 5);
    if (pick == 0 && eff <= 8) begin
      repeat (eff) put_item(REQ_TICK, 8'($urandom), rbit());
    end else begin
      if (pick == 1)
        put_item(REQ_TX, 8'($urandom), rbit());
      repeat ($urandom_range(0, 3)) put_item(REQ_RX, 8'($urandom), rbit());
      put_item(REQ_BREAK, 8'($urandom), rbit());
    end
  endtask

  task automatic line_noise();
    repeat ($urandom_range(1, 6))
      put_item(req_t'($urandom_range(0, 3)), 8'($urandom), rbit());
  endtask

  // receiver side
  initial begin
    res_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rx) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("break_framed_bus_transceiver: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int pick;
    logic [WD_W-1:0] phase_to [NPHASE];
    phase_to = '{16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd200, 16'd5, 16'd1};
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_RX;
    req_ch.data     = 8'h00;
    req_ch.tx_last  = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    quiet           = 1'b0;
    hold_rx         = 1'b0;
    sent            = 0;
    echo_to         = ECHO_TIMEOUT_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // first frame after reset is dropped
    put_item(REQ_RX, 8'h00, 1'b1);
    put_item(REQ_RX, 8'hFF, 1'b0);
    put_item(REQ_BREAK, 8'hFF, 1'b1);
    // lone break, then a one-byte frame
    put_item(REQ_BREAK, 8'h00, 1'b0);
    put_item(REQ_RX, 8'hA5, 1'b0);
    put_item(REQ_BREAK, 8'h00, 1'b0);
    // total of 4 is rejected
    repeat (3) put_item(REQ_RX, 8'($urandom), 1'b0);
    put_item(REQ_BREAK, 8'h00, 1'b0);
    // total of 5 is delivered
    repeat (4) put_item(REQ_RX, 8'($urandom), 1'b1);
    put_item(REQ_BREAK, 8'h00, 1'b0);
    put_item(REQ_TICK, 8'h3C, 1'b1);
    // two-byte telegram with busy rejects
    put_item(REQ_TX, 8'h55, 1'b0);
    put_item(REQ_TX, 8'h12, 1'b1);
    put_item(REQ_RX, 8'h55, 1'b0);
    put_item(REQ_TX, 8'hAA, 1'b1);
    put_item(REQ_RX, 8'hAA, 1'b0);
    put_item(REQ_TX, 8'h77, 1'b0);
    put_item(REQ_TICK, 8'h00, 1'b0);
    put_item(REQ_BREAK, 8'h00, 1'b0);
    // collisions in echo wait and between bytes
    put_item(REQ_TX, 8'h01, 1'b0);
    put_item(REQ_BREAK, 8'h00, 1'b0);
    put_item(REQ_TX, 8'h02, 1'b0);
    put_item(REQ_RX, 8'h02, 1'b0);
    put_item(REQ_TICK, 8'h00, 1'b0);
    put_item(REQ_BREAK, 8'h00, 1'b0);

    for (int ph = 0; ph < NPHASE; ph++) begin
      settle();
      write_echo_timeout((ph == NPHASE - 1) ? WD_W'($urandom_range(1, 6)) : phase_to[ph]);
      if (ph == 0) begin
        // output side holds off while a full frame is offered
        hold_rx = 1'b1;
        quiet   = 1'b1;
        put_item(REQ_BREAK, 8'($urandom), rbit());
        rx_frame(FRAME_DEPTH - 1);
        telegram();
        quiet = 1'b0;
      end
      while (sent < (ph + 1) * PHASE_ITEMS) begin
        quiet = ($urandom_range(0, 4) == 0);
        pick  = $urandom_range(0, 9);
        if (pick < 4) begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 7);
          rx_frame(len);
        end else if (pick < 8) begin
          telegram();
        end else begin
          line_noise();
        end
      end
    end
    quiet = 1'b0;
    settle();

    if (fail_count == 0)
      $display("break_framed_bus_transceiver: match");
    else
      $display("break_framed_bus_transceiver: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/bfbt_pkg.sv
rtl/bfbt_if.sv
rtl/bfbt_ram.sv
rtl/bfbt_ctrl.sv
rtl/bfbt_dp.sv
rtl/break_framed_bus_transceiver.sv
verif/bfbt_checker.sv
verif/tb_top.sv
